>>> sv/vscc_pkg.sv
// ----------------------------------------------------------------------------
// vscc_pkg: shared types and constants of the variable-size chunk cache
// Entry and payload structs, cell commands, controller states and register map.
// ----------------------------------------------------------------------------
package vscc_pkg;

	localparam int ID_BITS          = 16;
	localparam int SIZE_BITS        = 20;
	localparam int VSCC_MAX_ENTRIES = 64;
	localparam int CNT_BITS         = 32;
	localparam int SUM_BITS         = 64;

	localparam logic [SIZE_BITS-1:0] CAP_RESET = SIZE_BITS'(1024);

	// Register index, taken from paddr[2].
	localparam logic REG_POLICY   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	// Replacement policy codes.
	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU  = 1'b1;

	typedef struct packed {
		logic [ID_BITS-1:0]   vid;
		logic [ID_BITS-1:0]   chunk;
		logic [SIZE_BITS-1:0] size;
	} vscc_entry_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   media_id;
		logic [ID_BITS-1:0]   chunk_number;
		logic [SIZE_BITS-1:0] chunk_len;
	} vscc_req_t;

	typedef struct packed {
		logic                 hit;
		logic                 too_large;
		logic [SIZE_BITS-1:0] occupancy;
		logic [CNT_BITS-1:0]  hit_count;
		logic [CNT_BITS-1:0]  access_count;
		logic [SUM_BITS-1:0]  occupancy_sum;
	} vscc_rsp_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_L,
		OP_SHIFT_R,
		OP_MTF,
		OP_PUT_TAIL,
		OP_DROP_TAIL
	} vscc_op_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		vscc_op_t    op;
		vscc_entry_t req;
	} vscc_cell_ctl_t;

	// Runs from the tail cell toward the front cell.
	typedef struct packed {
		logic                 seen;
		vscc_entry_t          hit_entry;
		logic [SIZE_BITS-1:0] tail_size;
	} vscc_chain_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EVICT,
		ST_DONE
	} vscc_state_t;

endpackage

>>> sv/variable_size_chunk_cache.sv
// ----------------------------------------------------------------------------
// variable_size_chunk_cache: chunk cache with FIFO or LRU replacement
// Looks up each chunk request in a row of store cells, evicts and inserts,
// and reports hit, occupancy and running statistics.
// ----------------------------------------------------------------------------
// Usage: a request word (media_id, chunk_number, chunk_len) enters on the
// req channel; one response word leaves on the rsp channel for each request.
// The policy and capacity registers are set over the APB port at address 0
// and 4 while no request is in flight.
// A request is taken only while the controller is idle. A hit or an oversize
// request goes from LOOKUP to DONE, where it is loaded into the response register;
// other misses pass through EVICT on the way to DONE, staying there for each entry
// evicted, since the cell row drops one entry per cycle. The next request is
// accepted in the cycle after the response is loaded.
// The response sits in an output register, so one finished word may wait on
// a stalled receiver while the next request is worked on; that request then
// waits in its final state until the register is free.
// Reset empties the store, clears all counters and sets policy to FIFO and
// capacity to 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module variable_size_chunk_cache import vscc_pkg::*; #(
	parameter int MAX_ENTRIES = VSCC_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  vscc_req_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output vscc_rsp_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	vscc_state_t state_q, state_d;

	logic                 policy_q;
	logic [SIZE_BITS-1:0] cap_q;
	vscc_req_t            req_q;
	logic                 hit_q;
	logic                 large_q;
	logic [CNT_W-1:0]     count_q;
	logic [SIZE_BITS-1:0] used_q;
	logic [CNT_BITS-1:0]  hits_q;
	logic [CNT_BITS-1:0]  reqs_q;
	logic [SUM_BITS-1:0]  occ_q;
	vscc_rsp_t            rsp_q;
	logic                 rsp_valid_q;

	vscc_cell_ctl_t       ctl;
	vscc_op_t             cell_op;
	vscc_chain_t          chain_w [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] valid_vec;
	vscc_entry_t          entries [MAX_ENTRIES];
	vscc_entry_t          new_entry;

	logic                 match_any;
	logic                 oversize;
	logic [SIZE_BITS-1:0] free_space;
	logic                 need_evict;
	logic [SIZE_BITS-1:0] evict_size;
	logic                 cfg_wr;
	logic                 done_go;
	logic                 accept;
	logic [CNT_BITS-1:0]  hits_nxt;
	logic [CNT_BITS-1:0]  reqs_nxt;
	logic [SUM_BITS:0]    occ_add;
	logic [SUM_BITS-1:0]  occ_nxt;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'(policy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			cap_q    <= CAP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_POLICY:   policy_q <= pwdata[0];
				REG_CAPACITY: cap_q    <= pwdata[SIZE_BITS-1:0];
			endcase
		end
	end

	// ---------------- cell row ----------------
	assign new_entry.vid   = req_q.media_id;
	assign new_entry.chunk = req_q.chunk_number;
	assign new_entry.size  = req_q.chunk_len;
	assign ctl.req         = new_entry;
	assign ctl.op          = cell_op;

	assign chain_w[MAX_ENTRIES] = '0;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic        lv;
		vscc_entry_t le;
		logic        rv;
		vscc_entry_t re;

		if (g == 0) begin : g_front
			// The front cell takes the new or the hit entry when the row shifts back.
			assign lv = 1'b1;
			assign le = (ctl.op == OP_MTF) ? chain_w[0].hit_entry : new_entry;
		end else begin : g_mid
			assign lv = valid_vec[g-1];
			assign le = entries[g-1];
		end

		if (g == MAX_ENTRIES - 1) begin : g_last
			assign rv = 1'b0;
			assign re = '0;
		end else begin : g_inner
			assign rv = valid_vec[g+1];
			assign re = entries[g+1];
		end

		vscc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (lv),
			.left_entry  (le),
			.right_valid (rv),
			.right_entry (re),
			.chain_in    (chain_w[g+1]),
			.chain_out   (chain_w[g]),
			.valid       (valid_vec[g]),
			.entry       (entries[g])
		);
	end

	// ---------------- datapath decisions ----------------
	assign match_any  = chain_w[0].seen;
	assign oversize   = req_q.chunk_len > cap_q;
	assign free_space = (used_q >= cap_q) ? '0 : cap_q - used_q;
	assign need_evict = (count_q != '0) &&
		((free_space < req_q.chunk_len) || (count_q == CNT_W'(MAX_ENTRIES)));
	assign evict_size = (policy_q == POL_LRU) ? chain_w[0].tail_size : entries[0].size;

	assign hits_nxt = (hit_q && (hits_q != '1)) ? hits_q + CNT_BITS'(1) : hits_q;
	assign reqs_nxt = (reqs_q != '1) ? reqs_q + CNT_BITS'(1) : reqs_q;
	assign occ_add  = {1'b0, occ_q} + (SUM_BITS+1)'(used_q);
	assign occ_nxt  = occ_add[SUM_BITS] ? '1 : occ_add[SUM_BITS-1:0];

	// ---------------- controller ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (match_any || oversize) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (!need_evict) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (done_go) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cell_op   = OP_HOLD;
		done_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_LOOKUP: begin
				if (match_any && (policy_q == POL_LRU)) begin
					cell_op = OP_MTF;
				end
			end
			ST_EVICT: begin
				if (need_evict) begin
					cell_op = (policy_q == POL_LRU) ? OP_DROP_TAIL : OP_SHIFT_L;
				end else begin
					cell_op = (policy_q == POL_LRU) ? OP_SHIFT_R : OP_PUT_TAIL;
				end
			end
			ST_DONE: begin
				done_go = !rsp_valid_q || rsp_ready;
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			used_q      <= '0;
			hits_q      <= '0;
			reqs_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVICT) begin
				if (need_evict) begin
					count_q <= count_q - CNT_W'(1);
					used_q  <= used_q - evict_size;
				end else begin
					count_q <= count_q + CNT_W'(1);
					used_q  <= used_q + req_q.chunk_len;
				end
			end
			if (done_go) begin
				hits_q      <= hits_nxt;
				reqs_q      <= reqs_nxt;
				occ_q       <= occ_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_LOOKUP) begin
			hit_q   <= match_any;
			large_q <= !match_any && oversize;
		end
		if (done_go) begin
			rsp_q.hit           <= hit_q;
			rsp_q.too_large     <= large_q;
			rsp_q.occupancy     <= used_q;
			rsp_q.hit_count     <= hits_nxt;
			rsp_q.access_count  <= reqs_nxt;
			rsp_q.occupancy_sum <= occ_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_vec)) == count_q)
		else $error("entry count differs from the number of valid cells");

	a_empty_has_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (used_q == '0))
		else $error("empty store reports used space");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT && !need_evict) |-> (count_q < CNT_W'(MAX_ENTRIES)))
		else $error("insert into a full store");

	// A zero-size chunk may go in while a lowered capacity is still overbooked.
	a_insert_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT && !need_evict && req_q.chunk_len != '0) |=> (used_q <= cap_q))
		else $error("insert exceeds capacity");

	a_hit_not_large: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.too_large))
		else $error("response flags both hit and too_large");

endmodule

>>> sv/vscc_cell.sv
// ----------------------------------------------------------------------------
// vscc_cell: one slot of the ordered chunk store
// Holds one entry, compares it against the request key and shifts entries
// to or from its neighbors as the controller commands.
// ----------------------------------------------------------------------------
module vscc_cell import vscc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  vscc_cell_ctl_t ctl,
	input  logic           left_valid,
	input  vscc_entry_t    left_entry,
	input  logic           right_valid,
	input  vscc_entry_t    right_entry,
	input  vscc_chain_t    chain_in,
	output vscc_chain_t    chain_out,
	output logic           valid,
	output vscc_entry_t    entry
);

	logic        valid_q;
	vscc_entry_t entry_q;
	logic        valid_d;
	vscc_entry_t entry_d;
	logic        match;
	logic        tail;

	assign match = valid_q && (entry_q.vid == ctl.req.vid) && (entry_q.chunk == ctl.req.chunk);
	assign tail  = valid_q && !right_valid;

	assign chain_out.seen      = chain_in.seen | match;
	assign chain_out.hit_entry = chain_in.hit_entry | (match ? entry_q : '0);
	assign chain_out.tail_size = chain_in.tail_size | (tail ? entry_q.size : '0);

	assign valid = valid_q;
	assign entry = entry_q;

	always_comb begin
		valid_d = valid_q;
		entry_d = entry_q;
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_SHIFT_L: begin
				valid_d = right_valid;
				entry_d = right_entry;
			end
			OP_SHIFT_R: begin
				valid_d = left_valid;
				entry_d = left_entry;
			end
			OP_MTF: begin
				// Cells from the front up to the hit slot move back by one.
				if (chain_in.seen || match) begin
					valid_d = left_valid;
					entry_d = left_entry;
				end
			end
			OP_PUT_TAIL: begin
				if (!valid_q && left_valid) begin
					valid_d = 1'b1;
					entry_d = ctl.req;
				end
			end
			OP_DROP_TAIL: begin
				if (tail) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
